>>> src/sva_pkg.sv
`default_nettype none

package sva_pkg;

  // default voice counts
  localparam int TARGET_VOICES_DEF = 16;
  localparam int SOURCE_VOICES_DEF = 24;

  // command field width
  localparam int CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_KEY_OFF = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  // rotation direction through the cell row
  typedef enum logic {
    DIR_LEFT  = 1'b0,  // cell i takes cell i+1
    DIR_RIGHT = 1'b1   // cell i takes cell i-1
  } dir_t;

  // controls shared by every cell
  typedef struct packed {
    logic move;
    dir_t dir;
    logic ins_valid;
  } shift_ctrl_t;

  // per-cell selection
  typedef struct packed {
    logic in_range;
    logic take_ins;
  } cell_sel_t;

endpackage

`default_nettype wire

>>> src/synth_voice_allocator_unit.sv
`default_nettype none

// An accepted word passes through the find, move and report steps before its result
// word is registered on out_tdata; the report step waits while a previous result is
// stalled. No new word is taken until the last one is reported (in_tready in idle only).
// Reset (rst_n low, synchronous): all target voices sit free in cells
// 0..TARGET_VOICES-1 in order, no owners, no result pending.
module synth_voice_allocator_unit #(
  parameter int  TARGET_VOICES = sva_pkg::TARGET_VOICES_DEF,
  parameter int  SOURCE_VOICES = sva_pkg::SOURCE_VOICES_DEF,
  localparam int VW            = $clog2(TARGET_VOICES),
  localparam int SW            = $clog2(SOURCE_VOICES),
  localparam int CW            = sva_pkg::CMD_W,
  localparam int IN_W          = CW + SW + VW,
  localparam int OUT_W         = 2 + VW + SW,
  localparam int IN_DW         = ((IN_W + 7) / 8) * 8,
  localparam int OUT_DW        = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // command, source_voice, target_voice (from bit 0 up), zero padded
  input  wire logic [IN_DW-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // mapped, mapped_voice, owner_valid, owner_voice (from bit 0 up), zero padded
  output logic [OUT_DW-1:0]      out_tdata
);

  localparam int RCW    = $clog2(TARGET_VOICES + 1);
  localparam int N      = TARGET_VOICES;

  typedef enum logic [1:0] {ST_IDLE, ST_FIND, ST_MOVE, ST_REPORT} state_t;

  state_t               state_r;
  sva_pkg::cmd_t        cmd_r;
  logic [SW-1:0]        src_r;
  logic [VW-1:0]        tgt_r;
  logic [N-1:0]         hit_r;
  logic                 mapped_r;
  logic [RCW-1:0]       rc_r;     // length of the free segment at the front
  logic [RCW-1:0]       rc_nxt;
  logic                 out_tvalid_r;
  logic [OUT_DW-1:0]    out_tdata_r;

  // cell row wiring
  logic [VW-1:0]        cell_voice [N];
  logic                 cell_valid [N];
  logic [SW-1:0]        cell_owner [N];
  logic [N-1:0]         src_hits;
  logic [N-1:0]         tgt_hits;
  sva_pkg::cell_sel_t   cell_sel [N];
  sva_pkg::shift_ctrl_t ctrl;
  logic [VW-1:0]        ins_voice;
  logic [SW-1:0]        ins_owner;

  // move decode
  logic [N-1:0]         after_p;
  logic [N-1:0]         before_p;
  logic [N-1:0]         below_rc;
  logic                 p_free;
  logic [VW-1:0]        sel_voice;
  logic                 src_ok;

  // report values
  logic [VW-1:0]        rep_voice;
  logic                 rep_owner_valid;
  logic [SW-1:0]        rep_owner;
  logic [OUT_W-1:0]     rep_word;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign src_ok = ({1'b0, src_r} < (SW + 1)'(SOURCE_VOICES));

  // row of cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [VW-1:0] lv;
    logic          lval;
    logic [SW-1:0] lo;
    logic [VW-1:0] rv;
    logic          rval;
    logic [SW-1:0] ro;
    if (g == 0) begin : g_first
      assign lv   = cell_voice[g];
      assign lval = cell_valid[g];
      assign lo   = cell_owner[g];
    end else begin : g_mid_l
      assign lv   = cell_voice[g-1];
      assign lval = cell_valid[g-1];
      assign lo   = cell_owner[g-1];
    end
    if (g == N - 1) begin : g_last
      assign rv   = cell_voice[g];
      assign rval = cell_valid[g];
      assign ro   = cell_owner[g];
    end else begin : g_mid_r
      assign rv   = cell_voice[g+1];
      assign rval = cell_valid[g+1];
      assign ro   = cell_owner[g+1];
    end
    sva_cell #(
      .VW    (VW),
      .SW    (SW),
      .INDEX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sel         (cell_sel[g]),
      .ins_voice   (ins_voice),
      .ins_owner   (ins_owner),
      .left_voice  (lv),
      .left_valid  (lval),
      .left_owner  (lo),
      .right_voice (rv),
      .right_valid (rval),
      .right_owner (ro),
      .src_key     (src_r),
      .tgt_key     (tgt_r),
      .voice_r     (cell_voice[g]),
      .valid_r     (cell_valid[g]),
      .owner_r     (cell_owner[g]),
      .src_hit     (src_hits[g]),
      .tgt_hit     (tgt_hits[g])
    );
  end

  // position masks around the hit cell and the free/sounding boundary
  always_comb begin
    sel_voice = '0;
    for (int i = 0; i < N; i++) begin
      after_p[i]  = |(hit_r & ({N{1'b1}} >> (N - 1 - i)));
      before_p[i] = |(hit_r & ({N{1'b1}} << i));
      below_rc[i] = (RCW'(i) < rc_r);
      sel_voice   = sel_voice | ({VW{hit_r[i]}} & cell_voice[i]);
    end
    p_free = |(hit_r & below_rc);
  end

  // rotation control for the move step
  always_comb begin
    ctrl.move      = 1'b0;
    ctrl.dir       = sva_pkg::DIR_LEFT;
    ctrl.ins_valid = 1'b1;
    ins_voice      = sel_voice;
    ins_owner      = src_r;
    rc_nxt         = rc_r;
    for (int i = 0; i < N; i++) begin
      cell_sel[i].in_range = 1'b0;
      cell_sel[i].take_ins = 1'b0;
    end
    if (state_r == ST_MOVE && src_ok) begin
      case (cmd_r)
        sva_pkg::CMD_ALLOC: begin
          // reused or oldest voice goes to the back of the sounding segment
          ctrl.move = 1'b1;
          ctrl.dir  = sva_pkg::DIR_LEFT;
          if (!mapped_r) begin
            ins_voice = cell_voice[0];
          end
          for (int i = 0; i < N; i++) begin
            cell_sel[i].in_range = mapped_r ? after_p[i] : 1'b1;
            cell_sel[i].take_ins = (i == N - 1);
          end
          if (mapped_r ? p_free : (rc_r != '0)) begin
            rc_nxt = rc_r - RCW'(1);
          end
        end
        sva_pkg::CMD_KEY_OFF: begin
          // sounding voice moves to the back of the free segment
          if (mapped_r && !p_free) begin
            ctrl.move = 1'b1;
            ctrl.dir  = sva_pkg::DIR_RIGHT;
            for (int i = 0; i < N; i++) begin
              cell_sel[i].in_range = !below_rc[i] && before_p[i];
              cell_sel[i].take_ins = (RCW'(i) == rc_r);
            end
            rc_nxt = rc_r + RCW'(1);
          end
        end
        sva_pkg::CMD_RELEASE: begin
          // unmapped voice goes to the front
          if (mapped_r) begin
            ctrl.move      = 1'b1;
            ctrl.dir       = sva_pkg::DIR_RIGHT;
            ctrl.ins_valid = 1'b0;
            ins_owner      = '0;
            for (int i = 0; i < N; i++) begin
              cell_sel[i].in_range = before_p[i];
              cell_sel[i].take_ins = (i == 0);
            end
            if (!p_free) begin
              rc_nxt = rc_r + RCW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result lookup on the updated row
  always_comb begin
    rep_voice       = '0;
    rep_owner_valid = 1'b0;
    rep_owner       = '0;
    for (int i = 0; i < N; i++) begin
      rep_voice       = rep_voice | ({VW{src_hits[i]}} & cell_voice[i]);
      rep_owner_valid = rep_owner_valid | (tgt_hits[i] & cell_valid[i]);
      rep_owner       = rep_owner | ({SW{tgt_hits[i] & cell_valid[i]}} & cell_owner[i]);
    end
    rep_word = {rep_owner, rep_owner_valid, rep_voice, |src_hits};
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rc_r         <= RCW'(N);
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_FIND;
          end
        end
        ST_FIND: begin
          state_r <= ST_MOVE;
        end
        ST_MOVE: begin
          rc_r    <= rc_nxt;
          state_r <= ST_REPORT;
        end
        ST_REPORT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r <= OUT_DW'(rep_word);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      // result valid: set by a report, dropped once taken
      if (state_r == ST_REPORT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cmd_r <= sva_pkg::cmd_t'(in_tdata[CW-1:0]);
      src_r <= in_tdata[CW +: SW];
      tgt_r <= in_tdata[CW+SW +: VW];
    end
    if (state_r == ST_FIND) begin
      hit_r    <= src_hits;
      mapped_r <= |src_hits;
    end
  end

  // free segment never grows past the row
  a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= RCW'(N))
    else $error("free segment length out of range");

  // a source voice owns at most one cell
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MOVE |-> $onehot0(hit_r))
    else $error("source voice found in more than one cell");

  // accepted word starts the find step
  a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_FIND)
    else $error("accepted word did not start processing");

  // report waits while the previous result is stalled
  a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REPORT && out_tvalid_r && !out_tready |=> state_r == ST_REPORT)
    else $error("result overwritten while stalled");

  // mapping found only for in-range source voices
  a_mapped_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MOVE && mapped_r |-> src_ok)
    else $error("out-of-range source voice reported as mapped");

endmodule

`default_nettype wire

>>> src/sva_cell.sv
`default_nettype none

// One slot of the voice order: a target voice and its owning source voice.
module sva_cell #(
  parameter int VW    = 4,
  parameter int SW    = 5,
  parameter int INDEX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sva_pkg::shift_ctrl_t ctrl,
  input  wire sva_pkg::cell_sel_t   sel,
  input  wire logic [VW-1:0]        ins_voice,
  input  wire logic [SW-1:0]        ins_owner,
  input  wire logic [VW-1:0]        left_voice,
  input  wire logic                 left_valid,
  input  wire logic [SW-1:0]        left_owner,
  input  wire logic [VW-1:0]        right_voice,
  input  wire logic                 right_valid,
  input  wire logic [SW-1:0]        right_owner,
  input  wire logic [SW-1:0]        src_key,
  input  wire logic [VW-1:0]        tgt_key,
  output logic [VW-1:0]             voice_r,
  output logic                      valid_r,
  output logic [SW-1:0]             owner_r,
  output logic                      src_hit,
  output logic                      tgt_hit
);

  logic [VW-1:0] voice_nxt;
  logic          valid_nxt;
  logic [SW-1:0] owner_nxt;

  // pick own, neighbor or inserted entry
  always_comb begin
    voice_nxt = voice_r;
    valid_nxt = valid_r;
    owner_nxt = owner_r;
    if (ctrl.move && sel.in_range) begin
      if (sel.take_ins) begin
        voice_nxt = ins_voice;
        valid_nxt = ctrl.ins_valid;
        owner_nxt = ins_owner;
      end else if (ctrl.dir == sva_pkg::DIR_LEFT) begin
        voice_nxt = right_voice;
        valid_nxt = right_valid;
        owner_nxt = right_owner;
      end else begin
        voice_nxt = left_voice;
        valid_nxt = left_valid;
        owner_nxt = left_owner;
      end
    end
  end

  // reset puts voice INDEX here with no owner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_r <= VW'(INDEX);
      valid_r <= 1'b0;
      owner_r <= '0;
    end else begin
      voice_r <= voice_nxt;
      valid_r <= valid_nxt;
      owner_r <= owner_nxt;
    end
  end

  // lookups by owner and by voice
  assign src_hit = valid_r && (owner_r == src_key);
  assign tgt_hit = (voice_r == tgt_key);

endmodule

`default_nettype wire

>>> sim/synth_voice_allocator_unit_tb.sv
`default_nettype none

module synth_voice_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TGT_N     = 16;
  localparam int SRC_N     = 24;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int N_RANDOM  = 1900;
  localparam int IDLE_LIMIT = 5000;

  // one note event toward the allocator; hold waits for all reports first
  typedef struct {
    sva_pkg::cmd_t cmd;
    logic [4:0]    src;
    logic [3:0]    tgt;
    bit            hold;
  } note_event_t;

  // report word, fields from the top bit down
  typedef struct packed {
    logic [4:0] owner_voice;
    logic       owner_valid;
    logic [3:0] mapped_voice;
    logic       mapped;
  } voice_report_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  note_event_t   note_events[$];
  voice_report_t expected_reports[$];

  // allocator model state
  logic [3:0] free_voices[$];
  logic [3:0] sounding_voices[$];
  bit         owner_ok [TGT_N];
  logic [4:0] owner_src[TGT_N];
  bit         map_ok   [SRC_N];
  logic [3:0] map_tgt  [SRC_N];

  int  errors = 0;
  bit  in_took = 1'b0;
  bit  calm = 1'b0;
  int  phase_cnt = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  synth_voice_allocator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // drop a voice from a queue by value; 1 if it was there
  function automatic bit drop_voice(ref logic [3:0] q[$], input logic [3:0] v);
    for (int i = 0; i < q.size(); i++) begin
      if (q[i] == v) begin
        q.delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // apply one event to the model and return the report it yields
  function automatic voice_report_t step_allocator(sva_pkg::cmd_t cmd, logic [4:0] src,
                                                   logic [3:0] tgt);
    voice_report_t rep;
    logic [3:0]    v;
    bit            found;
    rep = '0;
    if (src < SRC_N) begin
      case (cmd)
        sva_pkg::CMD_ALLOC: begin
          if (map_ok[src]) begin
            // retrigger: back of the sounding queue
            v = map_tgt[src];
            void'(drop_voice(free_voices, v));
            void'(drop_voice(sounding_voices, v));
            if (sounding_voices.size() < TGT_N) sounding_voices.push_back(v);
          end else begin
            found = 1'b1;
            if (free_voices.size() != 0) v = free_voices.pop_front();
            else if (sounding_voices.size() != 0) v = sounding_voices.pop_front();
            else found = 1'b0;
            if (found) begin
              // steal: previous owner loses its voice
              if (owner_ok[v]) map_ok[owner_src[v]] = 1'b0;
              owner_ok[v]  = 1'b1;
              owner_src[v] = src;
              map_ok[src]  = 1'b1;
              map_tgt[src] = v;
              if (sounding_voices.size() < TGT_N) sounding_voices.push_back(v);
            end
          end
        end
        sva_pkg::CMD_KEY_OFF: begin
          if (map_ok[src]) begin
            v = map_tgt[src];
            if (drop_voice(sounding_voices, v) && free_voices.size() < TGT_N)
              free_voices.push_back(v);
          end
        end
        sva_pkg::CMD_RELEASE: begin
          if (map_ok[src]) begin
            v = map_tgt[src];
            void'(drop_voice(sounding_voices, v));
            void'(drop_voice(free_voices, v));
            owner_ok[v] = 1'b0;
            map_ok[src] = 1'b0;
            if (free_voices.size() < TGT_N) free_voices.push_front(v);
          end
        end
        default: ;
      endcase
      if (map_ok[src]) begin
        rep.mapped       = 1'b1;
        rep.mapped_voice = map_tgt[src];
      end
    end
    if (owner_ok[tgt]) begin
      rep.owner_valid = 1'b1;
      rep.owner_voice = owner_src[tgt];
    end
    return rep;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic add_event(sva_pkg::cmd_t c, int s, int t, bit h = 1'b0);
    note_event_t e;
    e.cmd  = c;
    e.src  = s[4:0];
    e.tgt  = t[3:0];
    e.hold = h;
    note_events.push_back(e);
  endtask

  task automatic note_fail(string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endtask

  // idling on/off stretches
  always @(posedge clk) begin
    phase_cnt <= (phase_cnt == 599) ? 0 : phase_cnt + 1;
    calm      <= (phase_cnt < 150);
  end

  // word driver
  always @(negedge clk) begin : drive_words
    note_event_t e;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (note_events.size() != 0 &&
                   !(note_events[0].hold && expected_reports.size() != 0)) begin
        e = note_events.pop_front();
        in_tdata  <= {5'b0, e.tgt, e.src, e.cmd};
        in_tvalid <= 1'b1;
        gap_left  <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin : drive_ready
    int g;
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = ($urandom_range(3) == 0) ? pick_gap() : 0;
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= g - 1;
      end
    end
  end

  // monitor: check results first, then predict for the accepted word
  always @(posedge clk) begin : watch_words
    voice_report_t got;
    voice_report_t want;
    bit            in_fire;
    bit            out_fire;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    in_took <= in_fire;

    if (out_fire) begin
      got = voice_report_t'(out_tdata[10:0]);
      if (expected_reports.size() == 0) begin
        note_fail($sformatf("unexpected result word %h", out_tdata));
      end else begin
        want = expected_reports.pop_front();
        if (got.mapped !== want.mapped || got.mapped_voice !== want.mapped_voice ||
            got.owner_valid !== want.owner_valid ||
            got.owner_voice !== want.owner_voice)
          note_fail($sformatf(
            "mismatch: exp mapped=%0d voice=%0d owner_valid=%0d owner=%0d, got %0d %0d %0d %0d",
            want.mapped, want.mapped_voice, want.owner_valid, want.owner_voice,
            got.mapped, got.mapped_voice, got.owner_valid, got.owner_voice));
      end
    end

    if (in_fire)
      expected_reports.push_back(step_allocator(sva_pkg::cmd_t'(in_tdata[1:0]),
                                                in_tdata[6:2], in_tdata[10:7]));

    // watchdog on cycles with no traffic
    if (!rst_n || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("synth_voice_allocator_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    int r;
    int s;
    int n;
    sva_pkg::cmd_t c;

    // model reset: all voices free in order, nothing mapped
    for (int i = 0; i < TGT_N; i++) begin
      free_voices.push_back(i[3:0]);
      owner_ok[i]  = 1'b0;
      owner_src[i] = '0;
    end
    for (int i = 0; i < SRC_N; i++) begin
      map_ok[i]  = 1'b0;
      map_tgt[i] = '0;
    end

    // directed: empty state, unmapped key off / release
    add_event(sva_pkg::CMD_QUERY, 0, 0);
    add_event(sva_pkg::CMD_KEY_OFF, 0, 0);
    add_event(sva_pkg::CMD_RELEASE, 1, 0);
    // first allocate, retrigger, key off twice, re-allocate a keyed-off voice
    add_event(sva_pkg::CMD_ALLOC, 0, 0);
    add_event(sva_pkg::CMD_ALLOC, 0, 0);
    add_event(sva_pkg::CMD_KEY_OFF, 0, 0);
    add_event(sva_pkg::CMD_KEY_OFF, 0, 0);
    add_event(sva_pkg::CMD_ALLOC, 0, 15);
    // source out of range is ignored
    add_event(sva_pkg::CMD_ALLOC, 31, 15);
    add_event(sva_pkg::CMD_KEY_OFF, 24, 0);
    add_event(sva_pkg::CMD_RELEASE, 30, 0);
    // fill every voice, then steal the oldest sounding one
    for (int i = 1; i <= 16; i++) add_event(sva_pkg::CMD_ALLOC, i + 7, i - 1);
    add_event(sva_pkg::CMD_RELEASE, 23, 15);
    add_event(sva_pkg::CMD_QUERY, 31, 15, 1'b1);

    // random: note traffic on valid sources with some out-of-range noise
    n = 0;
    while (n < N_RANDOM) begin
      if ($urandom_range(99) < 3) begin
        // burst of note-ons to provoke stealing
        for (int k = 0; k < 18; k++) begin
          add_event(sva_pkg::CMD_ALLOC, $urandom_range(SRC_N - 1),
                    $urandom_range(TGT_N - 1));
          n++;
        end
      end else begin
        r = $urandom_range(99);
        if (r < 45) c = sva_pkg::CMD_ALLOC;
        else if (r < 70) c = sva_pkg::CMD_KEY_OFF;
        else if (r < 82) c = sva_pkg::CMD_RELEASE;
        else c = sva_pkg::CMD_QUERY;
        s = ($urandom_range(99) < 8) ? $urandom_range(31, SRC_N) :
                                       $urandom_range(SRC_N - 1);
        add_event(c, s, $urandom_range(TGT_N - 1), (n % 350) == 349);
        n++;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (note_events.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("synth_voice_allocator_unit_tb OK");
    end else begin
      $display("synth_voice_allocator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> synth_voice_allocator_unit.f
src/sva_pkg.sv
src/sva_cell.sv
src/synth_voice_allocator_unit.sv
sim/synth_voice_allocator_unit_tb.sv
